// ----- design/pcsc_pkg.sv -----
// Shared types, constants and helpers for the pixel color space converter.
`default_nettype none

package pcsc_pkg;

    // Fixed-point fraction bits of the YUV->RGB coefficients (valid range 8..16)
    localparam int COEF_FRAC_BITS = 10;

    // Coefficients: decimal value times 2^COEF_FRAC_BITS, rounded half up
    localparam int K_Y  = (1164 * (1 << COEF_FRAC_BITS) + 500) / 1000;
    localparam int K_RV = (1596 * (1 << COEF_FRAC_BITS) + 500) / 1000;
    localparam int K_GV = (813 * (1 << COEF_FRAC_BITS) + 500) / 1000;
    localparam int K_GU = (391 * (1 << COEF_FRAC_BITS) + 500) / 1000;
    localparam int K_BU = (2018 * (1 << COEF_FRAC_BITS) + 500) / 1000;

    // Coefficients stay below 2.1 * 2^F: F+3 signed bits; times a 9-bit signed
    // offset, three terms summed, leaves F+14 bits with margin.
    localparam int ACC_W = COEF_FRAC_BITS + 14;

    localparam int Y_OFS  = 16;
    localparam int UV_OFS = 128;

    // floor(s/3) for s <= 765 as (s * 683) >> 11
    localparam int DIV3_MUL = 683;
    localparam int DIV3_SH  = 11;

    // Config register indexes
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_FORMAT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_FORMAT = 1'b1;

    typedef enum logic [1:0] {
        FMT_GRAY = 2'd0,
        FMT_RGB  = 2'd1,
        FMT_YUV  = 2'd2
    } t_fmt;

    typedef enum logic [2:0] {
        MODE_COPY3,     // RGB->RGB, YUV->YUV
        MODE_PASS_C0,   // gray->gray, YUV->gray
        MODE_GRAY2RGB,
        MODE_RGB2GRAY,
        MODE_YUV2RGB,
        MODE_UNSUP
    } t_mode;

    function automatic t_mode decode_mode(input logic [1:0] src, input logic [1:0] dst);
        t_mode m;
        if (src == dst && src == FMT_GRAY)
            m = MODE_PASS_C0;
        else if (src == dst && (src == FMT_RGB || src == FMT_YUV))
            m = MODE_COPY3;
        else if (src == FMT_GRAY && dst == FMT_RGB)
            m = MODE_GRAY2RGB;
        else if (src == FMT_RGB && dst == FMT_GRAY)
            m = MODE_RGB2GRAY;
        else if (src == FMT_YUV && dst == FMT_GRAY)
            m = MODE_PASS_C0;
        else if (src == FMT_YUV && dst == FMT_RGB)
            m = MODE_YUV2RGB;
        else
            m = MODE_UNSUP;
        return m;
    endfunction

    function automatic logic [7:0] div3(input logic [9:0] s);
        logic [20:0] p;
        p = 21'(s) * 21'(DIV3_MUL);
        return 8'(p >> DIV3_SH);
    endfunction

    // Floor-shift by the fraction bits, clamp to 0..255
    function automatic logic [7:0] sat8(input logic signed [ACC_W-1:0] acc);
        logic [ACC_W-2-COEF_FRAC_BITS:0] q;
        logic [7:0] r;
        q = acc[ACC_W-2:COEF_FRAC_BITS];
        if (acc[ACC_W-1])
            r = 8'd0;
        else if (|q[ACC_W-2-COEF_FRAC_BITS:8])
            r = 8'hFF;
        else
            r = q[7:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- design/pcsc_yuv2rgb.sv -----
// BT.601 YUV to RGB matrix, fixed point, truncate and saturate.
`default_nettype none

module pcsc_yuv2rgb (
    input  wire logic [7:0] i_y,
    input  wire logic [7:0] i_u,
    input  wire logic [7:0] i_v,
    output logic      [7:0] o_r,
    output logic      [7:0] o_g,
    output logic      [7:0] o_b
);

    localparam int AW = pcsc_pkg::ACC_W;

    localparam logic signed [AW-1:0] KY  = AW'(pcsc_pkg::K_Y);
    localparam logic signed [AW-1:0] KRV = AW'(pcsc_pkg::K_RV);
    localparam logic signed [AW-1:0] KGV = AW'(pcsc_pkg::K_GV);
    localparam logic signed [AW-1:0] KGU = AW'(pcsc_pkg::K_GU);
    localparam logic signed [AW-1:0] KBU = AW'(pcsc_pkg::K_BU);

    logic signed [9:0]    ys, us, vs;
    logic signed [AW-1:0] ye, ue, ve;
    logic signed [AW-1:0] luma, acc_r, acc_g, acc_b;

    always_comb begin
        ys = $signed({2'b00, i_y}) - 10'(pcsc_pkg::Y_OFS);
        us = $signed({2'b00, i_u}) - 10'(pcsc_pkg::UV_OFS);
        vs = $signed({2'b00, i_v}) - 10'(pcsc_pkg::UV_OFS);
        ye = AW'(ys);
        ue = AW'(us);
        ve = AW'(vs);
        // constant multiplies; sums fit in AW bits
        luma  = KY * ye;
        acc_r = luma + KRV * ve;
        acc_g = luma - KGV * ve - KGU * ue;
        acc_b = luma + KBU * ue;
        o_r = pcsc_pkg::sat8(acc_r);
        o_g = pcsc_pkg::sat8(acc_g);
        o_b = pcsc_pkg::sat8(acc_b);
    end

endmodule

`default_nettype wire

// ----- design/pixel_color_space_converter_top.sv -----
// Top level of the pixel color space converter: config, input stage, result stage.
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  config   | i_cfg_we, i_cfg_idx, i_cfg_data           | in
//  pixel in | i_start, o_busy, i_in_c0..i_in_c2         | in
//  result   | o_valid, o_out_c0..o_out_c2, o_conv_status| out
//
// One item per clock. An accepted item passes the input register, then the
// result register, and shows on the result ports from the result register.
// o_busy is always low: the two-stage pipe never needs to hold off a pixel.
// Synchronous active-low reset clears the formats to RGB->RGB and empties
// the pipe. The receiver cannot stall; o_valid is a one-cycle strobe.
`default_nettype none

module pixel_color_space_converter_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // config write port
    input  wire logic                            i_cfg_we,
    input  wire logic [pcsc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [pcsc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // pixel in
    input  wire logic                            i_start,
    output logic                                 o_busy,
    input  wire logic [7:0]                      i_in_c0,
    input  wire logic [7:0]                      i_in_c1,
    input  wire logic [7:0]                      i_in_c2,
    // result out
    output logic                                 o_valid,
    output logic [7:0]                           o_out_c0,
    output logic [7:0]                           o_out_c1,
    output logic [7:0]                           o_out_c2,
    output logic                                 o_conv_status
);

    // format registers
    logic [1:0] r_src_fmt, r_dst_fmt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_fmt <= pcsc_pkg::FMT_RGB;
            r_dst_fmt <= pcsc_pkg::FMT_RGB;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pcsc_pkg::CFG_SRC_FORMAT: r_src_fmt <= i_cfg_data;
                pcsc_pkg::CFG_DST_FORMAT: r_dst_fmt <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_busy = 1'b0;

    logic accept;
    assign accept = i_start && !o_busy;

    // input stage: pixel plus the decoded conversion for this item
    logic             r_s1_valid;
    pcsc_pkg::t_mode  r_s1_mode;
    logic [7:0]       r_s1_c0, r_s1_c1, r_s1_c2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_s1_valid <= 1'b0;
        else
            r_s1_valid <= accept;
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_mode <= pcsc_pkg::decode_mode(r_src_fmt, r_dst_fmt);
            r_s1_c0   <= i_in_c0;
            r_s1_c1   <= i_in_c1;
            r_s1_c2   <= i_in_c2;
        end
    end

    // conversion datapath
    logic [7:0] yuv_r, yuv_g, yuv_b;

    pcsc_yuv2rgb u_yuv2rgb (
        .i_y (r_s1_c0),
        .i_u (r_s1_c1),
        .i_v (r_s1_c2),
        .o_r (yuv_r),
        .o_g (yuv_g),
        .o_b (yuv_b)
    );

    logic [7:0] n_c0, n_c1, n_c2;
    logic       n_status;
    logic [9:0] rgb_sum;

    always_comb begin
        rgb_sum  = 10'(r_s1_c0) + 10'(r_s1_c1) + 10'(r_s1_c2);
        n_c0     = 8'd0;
        n_c1     = 8'd0;
        n_c2     = 8'd0;
        n_status = 1'b0;
        unique case (r_s1_mode)
            pcsc_pkg::MODE_COPY3: begin
                n_c0 = r_s1_c0;
                n_c1 = r_s1_c1;
                n_c2 = r_s1_c2;
            end
            pcsc_pkg::MODE_PASS_C0: begin
                n_c0 = r_s1_c0;
            end
            pcsc_pkg::MODE_GRAY2RGB: begin
                n_c0 = r_s1_c0;
                n_c1 = r_s1_c0;
                n_c2 = r_s1_c0;
            end
            pcsc_pkg::MODE_RGB2GRAY: begin
                n_c0 = pcsc_pkg::div3(rgb_sum);
            end
            pcsc_pkg::MODE_YUV2RGB: begin
                n_c0 = yuv_r;
                n_c1 = yuv_g;
                n_c2 = yuv_b;
            end
            default: begin
                n_status = 1'b1;
            end
        endcase
    end

    // result stage
    logic       r_out_valid;
    logic [7:0] r_out_c0, r_out_c1, r_out_c2;
    logic       r_out_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_out_valid <= 1'b0;
        else
            r_out_valid <= r_s1_valid;
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_out_c0     <= n_c0;
            r_out_c1     <= n_c1;
            r_out_c2     <= n_c2;
            r_out_status <= n_status;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_out_c0      = r_out_c0;
    assign o_out_c1      = r_out_c1;
    assign o_out_c2      = r_out_c2;
    assign o_conv_status = r_out_status;

`ifndef SYNTH
    // every accepted pixel yields a result after the input and result registers
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> ##1 o_valid)
        else $error("accepted pixel produced no result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> ##1 !o_valid)
        else $error("result without accepted pixel");

    a_unsup_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_conv_status |-> (o_out_c0 == 8'd0 && o_out_c1 == 8'd0 &&
                                      o_out_c2 == 8'd0))
        else $error("unsupported pair with nonzero components");

    a_gray_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && (r_s1_mode == pcsc_pkg::MODE_PASS_C0 ||
                       r_s1_mode == pcsc_pkg::MODE_RGB2GRAY)
        |=> (o_out_c1 == 8'd0 && o_out_c2 == 8'd0 && !o_conv_status))
        else $error("gray output with nonzero chroma components");
`endif

endmodule

`default_nettype wire
